>>> hdl/space_vector_pwm_duty_defines.svh
// Assertion macros shared by the space-vector PWM duty block.
// Needs nothing else; taken in by `include in the files that assert.
`ifndef SPACE_VECTOR_PWM_DUTY_DEFINES_SVH
`define SPACE_VECTOR_PWM_DUTY_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SVPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define SVPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/svpd_pkg.sv
// Package of the space-vector PWM duty block: constants, sector codes, job record.
// Depends on nothing; used by the interfaces and all modules.
package svpd_pkg;

    // Fixed-point constants (Q1.15)
    localparam logic [14:0] SQ3H_Q15    = 15'd28378;
    localparam logic [15:0] HALF_Q15    = 16'd16384;
    localparam logic [16:0] ONE_Q15     = 17'd32768;
    localparam logic [15:0] RATIO_RESET = 16'd32768;

    // Width of rounded projections and of the duty arithmetic
    localparam int XW = 20;
    localparam int DW = 24;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Sector codes: bit 0 beta axis, bit 1 axis at -30 deg, bit 2 axis at 210 deg
    localparam logic [2:0] SEC_ZERO = 3'd0;
    localparam logic [2:0] SEC_P1   = 3'd1;
    localparam logic [2:0] SEC_P2   = 3'd2;
    localparam logic [2:0] SEC_P12  = 3'd3;
    localparam logic [2:0] SEC_P3   = 3'd4;
    localparam logic [2:0] SEC_P13  = 3'd5;
    localparam logic [2:0] SEC_P23  = 3'd6;
    localparam logic [2:0] SEC_BAD  = 3'd7;

    // Classified vector handed from front to back
    typedef struct packed {
        logic signed [15:0] be;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic        [2:0]  sec;
    } t_job;

endpackage

>>> hdl/svpd_intf.sv
// Valid/ready channel interfaces of the space-vector PWM duty block.
// Depends on svpd_pkg.
interface svpd_in_if import svpd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [15:0] alpha_component;
    logic signed [15:0] beta_component;

    modport source (output valid, output alpha_component, output beta_component,
                    input ready);
    modport sink   (input valid, input alpha_component, input beta_component,
                    output ready);
endinterface

interface svpd_out_if import svpd_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] duty_phase_a;
    logic [15:0] duty_phase_b;
    logic [15:0] duty_phase_c;
    logic [2:0]  sector_code;

    modport source (output valid, output duty_phase_a, output duty_phase_b,
                    output duty_phase_c, output sector_code, input ready);
    modport sink   (input valid, input duty_phase_a, input duty_phase_b,
                    input duty_phase_c, input sector_code, output ready);
endinterface

interface svpd_cfg_if import svpd_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] modulation_ratio;

    modport source (output valid, output modulation_ratio, input ready);
    modport sink   (input valid, input modulation_ratio, output ready);
endinterface

>>> hdl/svpd_queue.sv
// Short job queue between the front (classify) and back (duty) parts.
// Depends on svpd_pkg and the assertion macro header.
`include "space_vector_pwm_duty_defines.svh"

module svpd_queue import svpd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QCW-1:0]   r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            if (w_push && !w_pop)      r_count <= r_count + 1'b1;
            else if (w_pop && !w_push) r_count <= r_count - 1'b1;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_job;
    end

    `SVPD_ASSERT_NXT(a_push_hold, i_clk, i_rst_n, i_push && o_full, i_push, "push dropped while queue full")
    `SVPD_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= QCW'(QDEPTH), "queue count out of range")

endmodule

>>> hdl/svpd_front.sv
// Front part: accepts vectors, forms the alpha/beta projection sums and the sector.
// Depends on svpd_pkg and the input channel interface.
module svpd_front import svpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svpd_in_if.sink     i_vec,
    input  logic [15:0] i_ratio,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic               r_v1;
    logic               r_v2;
    logic signed [30:0] r_kal;
    logic signed [15:0] r_be1;
    t_job               r_job;
    t_job               n_job;
    logic signed [30:0] n_kal;
    logic signed [31:0] w_hb;
    logic               w_rdy1;
    logic               w_rdy2;

    assign w_rdy2      = !r_v2 || !i_full;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign i_vec.ready = w_rdy1;
    assign o_push      = r_v2;
    assign o_job       = r_job;

    // Stage 1: k * alpha
    assign n_kal = 31'($signed({1'b0, SQ3H_Q15})) * 31'(i_vec.alpha_component);

    // Stage 2: Y and Z sums in Q30, sector from their signs and the sign of beta (zero when the ratio is zero)
    always_comb begin
        w_hb       = 32'(r_be1) <<< 14;
        n_job.be   = r_be1;
        n_job.sy   = 32'(r_kal) + w_hb;
        n_job.sz   = w_hb - 32'(r_kal);
        if (i_ratio != '0) begin
            n_job.sec = {n_job.sy[31], n_job.sz[31], (!r_be1[15] && (r_be1 != '0))};
        end else begin
            n_job.sec = SEC_ZERO;
        end
    end

    // Advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_vec.valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    // Load stage payloads
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_vec.valid) begin
            r_kal <= n_kal;
            r_be1 <= i_vec.beta_component;
        end
        if (w_rdy2 && r_v1) r_job <= n_job;
    end

endmodule

>>> hdl/svpd_back.sv
// Back part: scales by the ratio, rounds X/Y/Z, applies the sector rule, clamps.
// Depends on svpd_pkg, the output channel interface and the assertion macro header.
`include "space_vector_pwm_duty_defines.svh"

module svpd_back import svpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_ratio,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    svpd_out_if.source  o_duty
);

    // Stage valids
    logic r_va, r_vb, r_vc, r_vd;
    logic w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d;

    // Stage A: products
    logic signed [32:0] r_mx;
    logic signed [48:0] r_my;
    logic signed [48:0] r_mz;
    logic        [2:0]  r_sec_a;
    logic signed [32:0] n_mx;
    logic signed [48:0] n_my;
    logic signed [48:0] n_mz;

    // Stage B: rounded projections
    logic signed [XW-1:0] r_x, r_y, r_z;
    logic        [2:0]    r_sec_b;
    logic signed [34:0]   w_tx;
    logic signed [49:0]   w_ty;
    logic signed [49:0]   w_tz;

    // Stage C: centred start term
    logic signed [DW-1:0] r_s;
    logic signed [DW-1:0] r_xc, r_yc, r_zc;
    logic        [2:0]    r_sec_c;
    logic signed [DW-1:0] n_s;
    logic signed [DW-1:0] w_x, w_y, w_z, w_sum;

    // Stage D: output register
    logic [15:0] r_da, r_db, r_dc;
    logic [2:0]  r_sec_d;
    logic signed [DW-1:0] w_ta, w_tb, w_tc;

    function automatic logic [15:0] clamp_duty(input logic signed [DW-1:0] d);
        logic [15:0] q;
        if (d < 0) begin
            q = '0;
        end else if (d > $signed(DW'(ONE_Q15))) begin
            q = ONE_Q15[15:0];
        end else begin
            q = d[15:0];
        end
        return q;
    endfunction

    assign w_rdy_d = !r_vd || o_duty.ready;
    assign w_rdy_c = !r_vc || w_rdy_d;
    assign w_rdy_b = !r_vb || w_rdy_c;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_pop   = i_valid && w_rdy_a;

    // Stage A: scale by the modulation ratio
    assign n_mx = 33'($signed({1'b0, i_ratio})) * 33'(i_job.be);
    assign n_my = 49'($signed({1'b0, i_ratio})) * 49'(i_job.sy);
    assign n_mz = 49'($signed({1'b0, i_ratio})) * 49'(i_job.sz);

    // Stage B: round half up to Q15
    assign w_tx = 35'(r_mx) + 35'sd16384;
    assign w_ty = 50'(r_my) + 50'sd536870912;
    assign w_tz = 50'(r_mz) + 50'sd536870912;

    // Stage C: start term (1 +- t1 +- t2) / 2, rounded
    always_comb begin
        w_x = DW'(r_x);
        w_y = DW'(r_y);
        w_z = DW'(r_z);
        case (r_sec_b)
            SEC_P1:  w_sum = $signed(DW'(ONE_Q15)) - w_z - w_y + DW'(1);
            SEC_P2:  w_sum = $signed(DW'(ONE_Q15)) - w_y + w_x + DW'(1);
            SEC_P12: w_sum = $signed(DW'(ONE_Q15)) + w_z - w_x + DW'(1);
            SEC_P3:  w_sum = $signed(DW'(ONE_Q15)) + w_x - w_z + DW'(1);
            SEC_P13: w_sum = $signed(DW'(ONE_Q15)) - w_x + w_y + DW'(1);
            SEC_P23: w_sum = $signed(DW'(ONE_Q15)) + w_y + w_z + DW'(1);
            default: w_sum = $signed(DW'(ONE_Q15));
        endcase
        n_s = w_sum >>> 1;
    end

    // Stage D: remaining two duties from the start term
    always_comb begin
        case (r_sec_c)
            SEC_P1: begin
                w_tb = r_s; w_ta = r_s + r_zc; w_tc = r_s + r_zc + r_yc;
            end
            SEC_P2: begin
                w_ta = r_s; w_tc = r_s + r_yc; w_tb = r_s + r_yc - r_xc;
            end
            SEC_P12: begin
                w_ta = r_s; w_tb = r_s - r_zc; w_tc = r_s - r_zc + r_xc;
            end
            SEC_P3: begin
                w_tc = r_s; w_tb = r_s - r_xc; w_ta = r_s - r_xc + r_zc;
            end
            SEC_P13: begin
                w_tb = r_s; w_tc = r_s + r_xc; w_ta = r_s + r_xc - r_yc;
            end
            SEC_P23: begin
                w_tc = r_s; w_ta = r_s - r_yc; w_tb = r_s - r_yc - r_zc;
            end
            default: begin
                w_ta = r_s; w_tb = r_s; w_tc = r_s;
            end
        endcase
    end

    // Advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (w_rdy_a) r_va <= i_valid;
            if (w_rdy_b) r_vb <= r_va;
            if (w_rdy_c) r_vc <= r_vb;
            if (w_rdy_d) r_vd <= r_vc;
        end
    end

    // Load stage payloads
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mx    <= n_mx;
            r_my    <= n_my;
            r_mz    <= n_mz;
            r_sec_a <= i_job.sec;
        end
        if (w_rdy_b && r_va) begin
            r_x     <= w_tx[34:15];
            r_y     <= w_ty[49:30];
            r_z     <= w_tz[49:30];
            r_sec_b <= r_sec_a;
        end
        if (w_rdy_c && r_vb) begin
            r_s     <= (r_sec_b == SEC_ZERO) ? $signed(DW'(HALF_Q15)) : n_s;
            r_xc    <= w_x;
            r_yc    <= w_y;
            r_zc    <= w_z;
            r_sec_c <= r_sec_b;
        end
        if (w_rdy_d && r_vc) begin
            r_da    <= clamp_duty(w_ta);
            r_db    <= clamp_duty(w_tb);
            r_dc    <= clamp_duty(w_tc);
            r_sec_d <= r_sec_c;
        end
    end

    assign o_duty.valid        = r_vd;
    assign o_duty.duty_phase_a = r_da;
    assign o_duty.duty_phase_b = r_db;
    assign o_duty.duty_phase_c = r_dc;
    assign o_duty.sector_code  = r_sec_d;

    `SVPD_ASSERT_IMP(a_no_sector7, i_clk, i_rst_n, r_vd, r_sec_d != SEC_BAD, "sector seven on output")
    `SVPD_ASSERT_IMP(a_zero_half, i_clk, i_rst_n, r_vd && (r_sec_d == SEC_ZERO), (r_da == HALF_Q15) && (r_db == HALF_Q15) && (r_dc == HALF_Q15), "zero vector duty not one half")
    `SVPD_ASSERT_NXT(a_sec_carry, i_clk, i_rst_n, r_vc && w_rdy_d, r_sec_d == $past(r_sec_c), "sector lost between stages")

endmodule

>>> hdl/space_vector_pwm_duty.sv
// Top level of the space-vector PWM duty block: ratio register, front, queue, back.
// Depends on svpd_pkg, the channel interfaces, svpd_front, svpd_queue and svpd_back.
//
//   channel  dir  word                                              handshake
//   i_cfg    in   modulation_ratio[15:0]                            valid/ready
//   i_vec    in   alpha_component[15:0], beta_component[15:0]       valid/ready
//   o_duty   out  duty_phase_a/b/c[15:0], sector_code[2:0]          valid/ready
//
// One word in per cycle, one result out per cycle, while o_duty stays ready; a result
// passes two front stages, the queue and four back stages with the output register:
// seven registers, the first loaded at acceptance.
// The four-entry queue lets the front keep accepting while the back stalls on o_duty.
// i_vec.ready drops only once the queue and both front stages are full.
// Synchronous active-low reset empties all stages and sets the ratio to 1.0.
// i_cfg is always ready; a write also reaches words in flight, as the ratio is read in front stage 2 and back stage A.
module space_vector_pwm_duty import svpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    svpd_cfg_if.sink   i_cfg,
    svpd_in_if.sink    i_vec,
    svpd_out_if.source o_duty
);

    logic [15:0] r_ratio;
    logic        w_push;
    logic        w_full;
    logic        w_qvalid;
    logic        w_pop;
    t_job        w_fjob;
    t_job        w_qjob;

    assign i_cfg.ready = 1'b1;

    // Hold the modulation ratio
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_RESET;
        end else if (i_cfg.valid) begin
            r_ratio <= i_cfg.modulation_ratio;
        end
    end

    svpd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (i_vec),
        .i_ratio (r_ratio),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_fjob)
    );

    svpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_job   (w_qjob),
        .i_pop   (w_pop)
    );

    svpd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ratio (r_ratio),
        .i_valid (w_qvalid),
        .i_job   (w_qjob),
        .o_pop   (w_pop),
        .o_duty  (o_duty)
    );

endmodule

>>> dv/space_vector_pwm_duty_tb.sv
// Self-checking testbench of space_vector_pwm_duty: directed and random vectors under
// several modulation ratios and handshake idle patterns, checked against a duty predictor.
// Depends on svpd_pkg, the svpd channel interfaces and the space_vector_pwm_duty RTL.
`timescale 1ns / 100ps

module space_vector_pwm_duty_tb;
    import svpd_pkg::*;

    // Idle patterns of the two handshake sides
    typedef enum int {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SNK,
        IDLE_BOTH
    } t_idle_mode;

    // One expected result word
    typedef struct {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic [2:0]  sector;
    } t_duty_word;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int SETTLE_CYCLES   = 12;
    localparam int PRINT_CAP       = 50;

    // Predict duties from the current ratio and compare against the block
    class t_duty_book;
        logic [15:0] ratio;
        t_duty_word  expected_duties[$];
        int          mismatch_count;

        function new();
            ratio          = RATIO_RESET;
            mismatch_count = 0;
        endfunction

        function int pending();
            return expected_duties.size();
        endfunction

        // Shift right with round half up
        function longint round_shift(longint v, int n);
            return (v + (longint'(1) << (n - 1))) >>> n;
        endfunction

        function logic [15:0] clamp_duty(longint d);
            if (d < 0) return 16'd0;
            if (d > longint'(ONE_Q15)) return ONE_Q15[15:0];
            return d[15:0];
        endfunction

        task log_mismatch(string what);
            if (mismatch_count < PRINT_CAP)
                $display("[%0t] duty mismatch: %s", $realtime, what);
            mismatch_count++;
        endtask

        // Note an accepted vector and queue its expected duties
        function void note_vector(logic signed [15:0] alpha, logic signed [15:0] beta);
            longint     al, be, m, k, half, one;
            longint     p1, p2, p3, x, y, z, ta, tb, tc;
            logic [2:0] sec;
            t_duty_word w;
            al   = alpha;
            be   = beta;
            m    = longint'(ratio);
            k    = longint'(SQ3H_Q15);
            half = longint'(HALF_Q15);
            one  = longint'(ONE_Q15);

            // Sector from exact projection signs; zero ratio means zero vector
            p1  = be * one;
            p2  = k * al - half * be;
            p3  = -k * al - half * be;
            sec = SEC_ZERO;
            if (m != 0) begin
                if (p1 > 0) sec = sec | SEC_P1;
                if (p2 > 0) sec = sec | SEC_P2;
                if (p3 > 0) sec = sec | SEC_P3;
            end

            // Scaled projections in Q15
            x = round_shift(m * be, 15);
            y = round_shift(m * (k * al + half * be), 30);
            z = round_shift(m * (half * be - k * al), 30);

            // Centered symmetric placement per sector
            case (sec)
                SEC_P1: begin
                    tb = round_shift(one - z - y, 1); ta = tb + z; tc = ta + y;
                end
                SEC_P2: begin
                    ta = round_shift(one - y + x, 1); tc = ta + y; tb = tc - x;
                end
                SEC_P12: begin
                    ta = round_shift(one + z - x, 1); tb = ta - z; tc = tb + x;
                end
                SEC_P3: begin
                    tc = round_shift(one + x - z, 1); tb = tc - x; ta = tb + z;
                end
                SEC_P13: begin
                    tb = round_shift(one - x + y, 1); tc = tb + x; ta = tc - y;
                end
                SEC_P23: begin
                    tc = round_shift(one + y + z, 1); ta = tc - y; tb = ta - z;
                end
                default: begin
                    sec = SEC_ZERO; ta = half; tb = half; tc = half;
                end
            endcase

            w.duty_a = clamp_duty(ta);
            w.duty_b = clamp_duty(tb);
            w.duty_c = clamp_duty(tc);
            w.sector = sec;
            expected_duties.push_back(w);
        endfunction

        // Compare one accepted result against the oldest expectation
        task check_duty(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [2:0] sec);
            t_duty_word w;
            if (expected_duties.size() == 0) begin
                log_mismatch($sformatf("unexpected word a=%0d b=%0d c=%0d sector=%0d",
                                       a, b, c, sec));
            end else begin
                w = expected_duties.pop_front();
                if (a !== w.duty_a)
                    log_mismatch($sformatf("duty_phase_a got %0d want %0d", a, w.duty_a));
                if (b !== w.duty_b)
                    log_mismatch($sformatf("duty_phase_b got %0d want %0d", b, w.duty_b));
                if (c !== w.duty_c)
                    log_mismatch($sformatf("duty_phase_c got %0d want %0d", c, w.duty_c));
                if (sec !== w.sector)
                    log_mismatch($sformatf("sector_code got %0d want %0d", sec, w.sector));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    svpd_cfg_if cfg_if ();
    svpd_in_if  vec_if ();
    svpd_out_if duty_if ();

    t_duty_book duty_book;
    int         src_idle_pct;
    int         snk_idle_pct;

    space_vector_pwm_duty u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_vec   (vec_if),
        .o_duty  (duty_if)
    );

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Drive every input to a known value from time zero
    initial begin
        duty_book                = new();
        src_idle_pct             = 0;
        snk_idle_pct             = 0;
        i_rst_n                  = 1'b0;
        cfg_if.valid             = 1'b0;
        cfg_if.modulation_ratio  = '0;
        vec_if.valid             = 1'b0;
        vec_if.alpha_component   = '0;
        vec_if.beta_component    = '0;
        duty_if.ready            = 1'b1;
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        duty_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && duty_if.valid && duty_if.ready)
            duty_book.check_duty(duty_if.duty_phase_a, duty_if.duty_phase_b,
                                 duty_if.duty_phase_c, duty_if.sector_code);
    end

    task set_idle(t_idle_mode mode);
        src_idle_pct = (mode == IDLE_SRC) ? 86 : (mode == IDLE_BOTH) ? 38 : 0;
        snk_idle_pct = (mode == IDLE_SNK) ? 86 : (mode == IDLE_BOTH) ? 38 : 0;
    endtask

    // Offer one vector word, holding it until accepted
    task push_vector(logic signed [15:0] alpha, logic signed [15:0] beta);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            vec_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        vec_if.valid           <= 1'b1;
        vec_if.alpha_component <= alpha;
        vec_if.beta_component  <= beta;
        do @(posedge i_clk); while (!vec_if.ready);
        duty_book.note_vector(alpha, beta);
    endtask

    // Drop valid, wait for all results, then let the pipeline settle
    task wait_drained();
        @(negedge i_clk);
        vec_if.valid <= 1'b0;
        while (duty_book.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the ratio register while the block is idle
    task write_ratio(logic [15:0] value);
        wait_drained();
        @(negedge i_clk);
        cfg_if.valid            <= 1'b1;
        cfg_if.modulation_ratio <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        duty_book.ratio = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Random vectors with a mix of shapes; pause once for a full drain
    task run_random(int count);
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        int                 shape;
        int                 t;
        logic signed [15:0] edge_vals[5];
        edge_vals = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
        for (int i = 0; i < count; i++) begin
            shape = $urandom_range(9);
            alpha = 16'($urandom);
            beta  = 16'($urandom);
            case (shape)
                5: begin
                    alpha = 16'($signed(10'($urandom)));
                    beta  = 16'($signed(10'($urandom)));
                end
                6: begin
                    if ($urandom_range(1)) alpha = '0;
                    else beta = '0;
                end
                7: begin
                    // Vector on a sector boundary, possibly sign-flipped on alpha
                    t     = int'($urandom_range(4)) - 2;
                    alpha = 16'((($urandom_range(1)) ? 8192 : -8192) * t);
                    beta  = 16'(14189 * t);
                end
                8: begin
                    alpha = edge_vals[$urandom_range(4)];
                    beta  = edge_vals[$urandom_range(4)];
                end
                9: begin
                    alpha = ($urandom_range(1)) ? 16'(16'sd32767 - $urandom_range(63))
                                                : 16'(-16'sd32768 + $urandom_range(63));
                    beta  = ($urandom_range(1)) ? 16'(16'sd32767 - $urandom_range(63))
                                                : 16'(-16'sd32768 + $urandom_range(63));
                end
                default: ;
            endcase
            if (i == count / 2)
                wait_drained();
            push_vector(alpha, beta);
        end
    endtask

    // Main sequence
    initial begin
        logic signed [15:0] dir_alpha[20];
        logic signed [15:0] dir_beta[20];
        logic [15:0]        phase_ratio[RANDOM_PHASES];
        dir_alpha = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd32767,
                      -16'sd32768, 16'sd32767, -16'sd32768, 16'sd28378, -16'sd28378,
                      16'sd0, 16'sd1, -16'sd1, 16'sd0, 16'sd8192, -16'sd8192,
                      16'sd8192, 16'sd16384, -16'sd1};
        dir_beta  = '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd32767,
                      -16'sd32768, -16'sd32768, 16'sd32767, 16'sd16384, 16'sd16384,
                      -16'sd16384, 16'sd0, 16'sd0, 16'sd1, 16'sd14189, 16'sd14189,
                      -16'sd14189, 16'sd28378, -16'sd1};
        phase_ratio = '{16'd0, 16'd65535, 16'd32768, 16'd1, 16'($urandom),
                        16'd32767, 16'($urandom_range(32768)), 16'd16384};

        // Hold reset, then release it on a falling clock edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed vectors at the reset ratio
        set_idle(IDLE_NONE);
        for (int i = 0; i < 20; i++)
            push_vector(dir_alpha[i], dir_beta[i]);

        // Random phases across ratios and idle patterns
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_ratio(phase_ratio[p]);
            set_idle(t_idle_mode'(p % 4));
            run_random(ITEMS_PER_PHASE);
        end

        wait_drained();
        if (duty_book.pending() != 0)
            duty_book.log_mismatch("expected words left over");
        if (duty_book.mismatch_count == 0) begin
            $display("space_vector_pwm_duty_tb OK");
        end else begin
            $display("space_vector_pwm_duty_tb NOT OK");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #1000000;
        $display("space_vector_pwm_duty_tb NOT OK");
        $finish;
    end

endmodule
